### hw/rtl/itar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_pkg
// Shared types, constants and the digit encoder for the integer-to-ASCII core.
// ----------------------------------------------------------------------------
package itar_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    // Classification of one queued transaction
    typedef struct packed {
        logic               neg;
        logic [RADIX_W-1:0] base;
    } t_job_ctl;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        if (d < RADIX_DEC) begin
            return CHAR_ZERO + {2'b00, d};
        end else begin
            return CHAR_A + {2'b00, d} - {2'b00, RADIX_DEC};
        end
    endfunction

endpackage

### hw/rtl/integer_to_ascii_radix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Converts one integer per transaction into ASCII text in a configurable base.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall | i_number
//   out     | output    | o_out_valid/i_out_stall | o_character, o_last_char
//   cfg     | input     | i_cfg_we                | i_cfg_data (radix)
//
// The long-division loop retires eight quotient bits a cycle, then the digit
// store feeds one character a cycle while the output is not stalled.
// A two-entry queue takes new numbers while the back end works.
// Reset is synchronous; the radix returns to ten.
// A stalled output holds the back end; the queue stalls the input when full.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_core #(
    parameter int VALUE_BITS  = 32,
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [itar_pkg::RADIX_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_BITS-1:0]  i_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [itar_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last_char
);

    logic                  job_valid;
    logic                  job_ready;
    logic [VALUE_BITS-1:0] job_mag;
    itar_pkg::t_job_ctl    job_ctl;

    itar_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_number    (i_number),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_mag   (job_mag),
        .o_job_ctl   (job_ctl)
    );

    itar_back #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_mag   (job_mag),
        .i_job_ctl   (job_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule

### hw/rtl/itar_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itar_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/itar_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_front
// Holds the radix register, classifies incoming numbers (sign, magnitude,
// effective base) and buffers them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module itar_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [itar_pkg::RADIX_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [VALUE_BITS-1:0]   i_number,
    output logic                           o_job_valid,
    input  logic                           i_job_ready,
    output logic [VALUE_BITS-1:0]          o_job_mag,
    output itar_pkg::t_job_ctl             o_job_ctl
);

    logic [itar_pkg::RADIX_W-1:0] r_radix;
    logic [itar_pkg::RADIX_W-1:0] eff_base;
    logic [VALUE_BITS-1:0]        raw;
    logic [VALUE_BITS-1:0]        mag;
    logic                         neg;

    logic [VALUE_BITS-1:0]   r_mag [2];
    itar_pkg::t_job_ctl      r_ctl [2];
    logic                    r_wp;
    logic                    r_rp;
    logic [1:0]              r_count;
    logic                    push;
    logic                    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itar_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    always_comb begin
        unique if (r_radix < itar_pkg::RADIX_MIN) begin
            eff_base = itar_pkg::RADIX_MIN;
        end else if (r_radix > itar_pkg::RADIX_MAX) begin
            eff_base = itar_pkg::RADIX_MAX;
        end else begin
            eff_base = r_radix;
        end
    end

    // Only base ten is signed; other bases take the raw bit pattern
    assign raw = i_number;
    assign neg = (eff_base == itar_pkg::RADIX_DEC) && raw[VALUE_BITS-1];
    assign mag = neg ? (~raw + VALUE_BITS'(1)) : raw;

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_count != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job_mag   = r_mag[r_rp];
    assign o_job_ctl   = r_ctl[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mag[r_wp]      <= mag;
            r_ctl[r_wp].neg  <= neg;
            r_ctl[r_wp].base <= eff_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### hw/rtl/itar_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_back
// Extracts digits by repeated long division (eight quotient bits a cycle),
// stores them least significant first, then emits the text most significant
// first through an output register.
// ----------------------------------------------------------------------------
module itar_back #(
    parameter int VALUE_BITS  = 32,
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  logic [VALUE_BITS-1:0]         i_job_mag,
    input  itar_pkg::t_job_ctl            i_job_ctl,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [itar_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last_char
);

    localparam int NCHUNK = (VALUE_BITS + 7) / 8;
    localparam int W      = NCHUNK * 8;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int AW     = $clog2(DIGIT_SLOTS);
    localparam int RW     = itar_pkg::RADIX_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0]                 r_state,     n_state;
    logic [W-1:0]               r_work,      n_work;
    logic [RW-1:0]              r_rem,       n_rem;
    logic [CW-1:0]              r_chunk,     n_chunk;
    logic [AW-1:0]              r_cnt,       n_cnt;
    logic [AW-1:0]              r_idx,       n_idx;
    itar_pkg::t_job_ctl         r_ctl,       n_ctl;
    logic                       r_out_valid, n_out_valid;
    logic [itar_pkg::CHAR_W-1:0] r_char,     n_char;
    logic                       r_last,      n_last;

    logic [W-1:0]   div_work;
    logic [RW-1:0]  div_rem;
    logic           out_free;
    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [RW-1:0]  ram_rdata;

    // Eight restoring-division steps on the top byte of the working word
    always_comb begin
        logic [RW:0]    t;
        logic [RW-1:0]  rem;
        logic [7:0]     qbits;
        logic [W+7:0]   wide;
        rem   = r_rem;
        qbits = '0;
        for (int k = 0; k < 8; k++) begin
            t = {rem, r_work[W-1-k]};
            if (t >= {1'b0, r_ctl.base}) begin
                qbits[7-k] = 1'b1;
                t          = t - {1'b0, r_ctl.base};
            end
            rem = t[RW-1:0];
        end
        wide     = {r_work, qbits};
        div_work = wide[W-1:0];
        div_rem  = rem;
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_job_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_ctl       = r_ctl;
        n_out_valid = r_out_valid && i_out_stall;
        n_char      = r_char;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_work  = W'(i_job_mag);
                    n_ctl   = i_job_ctl;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_work = div_work;
                n_rem  = div_rem;
                if (r_chunk == CW'(NCHUNK - 1)) begin
                    // Digit complete: store remainder, continue on the quotient
                    ram_we  = 1'b1;
                    n_chunk = '0;
                    n_rem   = '0;
                    if (div_work == '0 || r_cnt == AW'(DIGIT_SLOTS - 1)) begin
                        n_idx   = r_cnt;
                        n_state = r_ctl.neg ? ST_SIGN : ST_READ;
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                    end
                end else begin
                    n_chunk = r_chunk + CW'(1);
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = itar_pkg::CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = itar_pkg::digit_to_ascii(ram_rdata);
                    n_last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        // Prefetch the next lower digit while this one goes out
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - AW'(1);
                        n_idx     = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_chunk     <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_idx  <= n_idx;
        r_ctl  <= n_ctl;
        r_char <= n_char;
        r_last <= n_last;
    end

    itar_ram #(
        .WIDTH (RW),
        .DEPTH (DIGIT_SLOTS)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

`ifndef SYNTHESIS
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_ctl.base))
        else $error("partial remainder not below base");

    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |->
        (r_ctl.base >= itar_pkg::RADIX_MIN && r_ctl.base <= itar_pkg::RADIX_MAX))
        else $error("working base out of range");

    a_digit_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (ram_rdata < r_ctl.base))
        else $error("stored digit not below base");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && out_free && r_idx == '0) |=>
        (r_state == ST_IDLE && r_out_valid && r_last))
        else $error("final character did not end the transaction");
`endif

endmodule

### bench/tb_integer_to_ascii_radix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_core
// Self-checking bench for the integer-to-ASCII core. A clocked driver feeds
// numbers from a queue and randomly idles. A clocked monitor checks every
// character against a text predictor. The predictor runs on each input
// transaction and uses its own copy of the radix register. The radix is
// rewritten between phases while the core is idle. The phases cover the
// extreme and clamped bases, and also include a long output hold-off and a
// stretch with no idling.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_core;

    localparam int VALUE_W      = 32;
    localparam int DIGIT_MAX    = 32;
    localparam int RADIX_BITS   = itar_pkg::RADIX_W;
    localparam int RANDOM_ITEMS = 88;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [itar_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [itar_pkg::RADIX_W-1:0]  i_cfg_data  = itar_pkg::RADIX_RESET;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic [VALUE_W-1:0]            i_number    = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [itar_pkg::CHAR_W-1:0]   o_character;
    logic                          o_last_char;

    logic [VALUE_W-1:0]            pending_numbers[$];
    t_text_char                    expected_text[$];
    logic [itar_pkg::RADIX_W-1:0]  radix_setting = itar_pkg::RADIX_RESET;

    logic                 in_took       = 1'b0;
    logic                 out_took      = 1'b0;
    logic                 in_no_gap     = 1'b0;
    logic                 out_no_gap    = 1'b0;
    logic                 long_hold_req = 1'b0;
    logic                 stall_next;
    int                   in_idle_left  = 0;
    int                   stall_left    = 0;
    int                   hold_left     = 0;
    int                   quiet_cycles  = 0;
    int                   mismatches    = 0;

    integer_to_ascii_radix_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Text of one number, most significant character first
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [itar_pkg::RADIX_W-1:0] base;
        logic [VALUE_W-1:0]           mag;
        logic [VALUE_W-1:0]           divisor;
        logic [VALUE_W-1:0]           rem;
        logic [itar_pkg::RADIX_W-1:0] digits[DIGIT_MAX];
        t_text_char                   ch;
        int                           n;
        int                           i;
        if (radix_setting < itar_pkg::RADIX_MIN) begin
            base = itar_pkg::RADIX_MIN;
        end else if (radix_setting > itar_pkg::RADIX_MAX) begin
            base = itar_pkg::RADIX_MAX;
        end else begin
            base = radix_setting;
        end
        divisor = {{(VALUE_W-itar_pkg::RADIX_W){1'b0}}, base};
        mag = value;
        if (base == itar_pkg::RADIX_DEC && value[VALUE_W-1]) begin
            mag = ~value + 1'b1;
            ch.code = itar_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            expected_text.push_back(ch);
        end
        n = 0;
        do begin
            rem = mag % divisor;
            digits[n] = rem[itar_pkg::RADIX_W-1:0];
            mag = mag / divisor;
            n++;
        end while (mag != 0 && n < DIGIT_MAX);
        for (i = n - 1; i >= 0; i--) begin
            if (digits[i] < itar_pkg::RADIX_DEC) begin
                ch.code = itar_pkg::CHAR_ZERO + {2'b00, digits[i]};
            end else begin
                ch.code = itar_pkg::CHAR_A + {2'b00, digits[i]}
                          - {2'b00, itar_pkg::RADIX_DEC};
            end
            ch.last = (i == 0);
            expected_text.push_back(ch);
        end
    endfunction

    // Input side: record transactions and predict their text
    always @(posedge i_clk) begin
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (in_took) begin
            predict_text(i_number);
        end
    end

    // Output side: compare each character with the oldest expectation
    always @(posedge i_clk) begin
        t_text_char exp_ch;
        out_took = i_rst_n && o_out_valid && !i_out_stall;
        if (out_took) begin
            if (expected_text.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected character expected none actual %h last %b",
                         $time, o_character, o_last_char);
            end else begin
                exp_ch = expected_text.pop_front();
                if (o_character !== exp_ch.code) begin
                    mismatches++;
                    $display("%0t: character mismatch expected %h actual %h",
                             $time, exp_ch.code, o_character);
                end
                if (o_last_char !== exp_ch.last) begin
                    mismatches++;
                    $display("%0t: last_char mismatch expected %b actual %b",
                             $time, exp_ch.last, o_last_char);
                end
            end
        end
    end

    // Driver: hold a stalled transaction, otherwise idle or launch the next number
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_took) begin
            i_in_valid <= 1'b1;
        end else if (in_idle_left != 0) begin
            in_idle_left--;
            i_in_valid <= 1'b0;
        end else if (pending_numbers.size() != 0) begin
            i_number   <= pending_numbers.pop_front();
            i_in_valid <= 1'b1;
            in_idle_left = in_no_gap ? 0 : $urandom_range(0, 9);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: random stall per character, plus the occasional long hold-off
    always @(negedge i_clk) begin
        if (out_took) begin
            stall_left = out_no_gap ? 0 : $urandom_range(0, 9);
        end
        if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            stall_next = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_numbers.size() != 0 || i_in_valid || expected_text.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_radix(input logic [itar_pkg::RADIX_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        radix_setting = value;
    endtask

    function automatic logic [VALUE_W-1:0] random_number();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 99);
            2: return 32'd0 - $urandom_range(1, 99);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    initial begin
        int sent;
        int phase;
        int count;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: decimal signs, extremes of base, clamped bases
        write_radix(itar_pkg::RADIX_DEC);
        pending_numbers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'd1234567890};
        write_radix(6'd2);
        pending_numbers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000};
        write_radix(6'd36);
        pending_numbers = '{32'd35, 32'd36, 32'hFFFF_FFFF, 32'h8000_0000};
        write_radix(6'd16);
        pending_numbers = '{32'hFEDC_BA98};
        write_radix(6'd0);
        pending_numbers = '{32'd5};
        write_radix(6'd1);
        pending_numbers = '{32'hFFFF_FFFF};
        write_radix(6'd37);
        pending_numbers = '{32'd71};
        write_radix(6'd63);
        pending_numbers = '{32'hFFFF_FFFF};

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: write_radix(itar_pkg::RADIX_DEC);
                1: write_radix(itar_pkg::RADIX_MIN);
                2: write_radix(itar_pkg::RADIX_MAX);
                3: write_radix(RADIX_BITS'($urandom_range(0, 63)));
                default: write_radix(RADIX_BITS'($urandom_range(2, 36)));
            endcase
            in_no_gap  = (phase == 2 || phase == 4);
            out_no_gap = (phase == 4);
            // Fill the core behind a stalled output
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            count = $urandom_range(5, 15);
            repeat (count) pending_numbers.push_back(random_number());
            sent += count;
            phase++;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
